@@ rtl/sacf_pkg.sv @@
// Shared constants and types for the set-associative tag store with FIFO replacement.
package sacf_pkg;

	// Parameter defaults
	localparam int DEF_SET_COUNT = 64;
	localparam int DEF_WAYS      = 4;
	localparam int DEF_ADDR_BITS = 32;

	// Fixed stream payload widths
	localparam int IN_ADDR_W   = 32;
	localparam int OUT_WAY_W   = 2;
	localparam int OUT_TDATA_W = 8;

	// Lookup outcome handed from the compare logic to the pipeline
	typedef struct packed {
		logic hit;
		logic evicted;
		logic wr_en;
	} lkp_res_t;

endpackage

@@ rtl/sacf_tag_ram.sv @@
// Per-set tag row memory and FIFO pointer memory with same-set write forwarding.
module sacf_tag_ram
	import sacf_pkg::*;
#(
	parameter int SET_COUNT = DEF_SET_COUNT,
	parameter int WAYS      = DEF_WAYS,
	parameter int TAG_W     = DEF_ADDR_BITS,
	parameter int SET_W     = 1,
	parameter int WAY_W     = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [SET_W-1:0]             rd_set,
	output logic [WAYS-1:0][TAG_W-1:0]   rd_row,
	output logic [WAY_W-1:0]             rd_ptr,
	input  logic                         wr_en,
	input  logic [SET_W-1:0]             wr_set,
	input  logic [WAYS-1:0][TAG_W-1:0]   wr_row,
	input  logic [WAY_W-1:0]             wr_ptr
);

	logic [WAYS-1:0][TAG_W-1:0] row_mem [SET_COUNT];
	logic [WAY_W-1:0]           ptr_mem [SET_COUNT];
	logic [SET_COUNT-1:0]       ptr_vld_q;

	logic [WAYS-1:0][TAG_W-1:0] row_rd_q;
	logic [WAY_W-1:0]           ptr_rd_q;
	logic                       ptr_rd_vld_q;
	logic                       fwd_q;
	logic [WAYS-1:0][TAG_W-1:0] fwd_row_q;
	logic [WAY_W-1:0]           fwd_ptr_q;

	// Write the row and pointer, register the read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[wr_set] <= wr_row;
			ptr_mem[wr_set] <= wr_ptr;
		end
		if (rd_en) begin
			row_rd_q  <= row_mem[rd_set];
			ptr_rd_q  <= ptr_mem[rd_set];
			fwd_row_q <= wr_row;
			fwd_ptr_q <= wr_ptr;
		end
	end

	// Pointer valid flags: an unwritten pointer reads as way zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_vld_q    <= '0;
			ptr_rd_vld_q <= 1'b0;
			fwd_q        <= 1'b0;
		end else begin
			if (wr_en) begin
				ptr_vld_q[wr_set] <= 1'b1;
			end
			if (rd_en) begin
				ptr_rd_vld_q <= ptr_vld_q[rd_set];
				fwd_q        <= wr_en && (wr_set == rd_set);
			end
		end
	end

	// Bypass the memory when the previous transaction wrote the same set
	always_comb begin
		if (fwd_q) begin
			rd_row = fwd_row_q;
			rd_ptr = fwd_ptr_q;
		end else begin
			rd_row = row_rd_q;
			rd_ptr = ptr_rd_vld_q ? ptr_rd_q : '0;
		end
	end

endmodule

@@ rtl/sacf_lookup.sv @@
// Parallel way compare, free-way search and FIFO victim selection for one set.
module sacf_lookup
	import sacf_pkg::*;
#(
	parameter int WAYS  = DEF_WAYS,
	parameter int TAG_W = DEF_ADDR_BITS,
	parameter int WAY_W = 1
) (
	input  logic [TAG_W-1:0]             tag,
	input  logic [WAYS-1:0][TAG_W-1:0]   row,
	input  logic [WAYS-1:0]              vld,
	input  logic [WAY_W-1:0]             ptr,
	output lkp_res_t                     res,
	output logic [WAY_W-1:0]             way,
	output logic [WAYS-1:0][TAG_W-1:0]   new_row,
	output logic [WAY_W-1:0]             new_ptr
);

	logic             hit;
	logic [WAY_W-1:0] hit_way;
	logic             free;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] victim;

	// Compare all ways; keep the lowest invalid way
	always_comb begin
		hit      = 1'b0;
		hit_way  = '0;
		free     = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (vld[w] && (row[w] == tag)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!vld[w]) begin
				free     = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	// Fill a free way, else replace the oldest and advance the pointer
	always_comb begin
		victim  = free ? free_way : ptr;
		new_row = row;
		new_row[victim] = tag;
		if (free) begin
			new_ptr = ptr;
		end else if (ptr == WAY_W'(WAYS - 1)) begin
			new_ptr = '0;
		end else begin
			new_ptr = ptr + WAY_W'(1);
		end
		way         = hit ? hit_way : victim;
		res.hit     = hit;
		res.evicted = !hit && !free;
		res.wr_en   = !hit;
	end

endmodule

@@ rtl/set_assoc_cache_tags_fifo.sv @@
// Top level: set-associative cache tag store with FIFO replacement, one access per cycle.
// Pipeline: an accepted address is registered in stage 1, then its result in the result register.
// Throughput: one access per cycle; a held result stalls stage 1 and the input. The tag row and
// pointer memories are read once per access, and a write to the set just read is forwarded.
// Reset: arst_n clears line valid bits, pointer valid flags and pipeline valids at once;
// the tag memory is not cleared and there is no clearing pass.
module set_assoc_cache_tags_fifo
	import sacf_pkg::*;
#(
	parameter int SET_COUNT = DEF_SET_COUNT,
	parameter int WAYS      = DEF_WAYS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_ADDR_W-1:0]   s_axis_tdata,   // [31:0] address
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] hit, [2:1] way, [3] evicted, [7:4] zero
);

	localparam int LOG_SETS = $clog2(SET_COUNT);
	localparam int SET_W    = (LOG_SETS > 0) ? LOG_SETS : 1;
	localparam int TAG_W    = ADDR_BITS - LOG_SETS;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [ADDR_BITS-1:0]       addr;
	logic [SET_W-1:0]           in_set;
	logic [TAG_W-1:0]           in_tag;

	logic                       vld_s1;
	logic [SET_W-1:0]           set_s1;
	logic [TAG_W-1:0]           tag_s1;
	logic                       adv_s1;
	logic                       accept;

	logic [WAYS-1:0]            line_vld_q [SET_COUNT];
	logic [WAYS-1:0]            row_vld_s1;

	logic [WAYS-1:0][TAG_W-1:0] rd_row;
	logic [WAY_W-1:0]           rd_ptr;
	lkp_res_t                   res;
	logic [WAY_W-1:0]           way;
	logic [WAYS-1:0][TAG_W-1:0] new_row;
	logic [WAY_W-1:0]           new_ptr;

	logic                       out_vld_q;
	logic                       out_hit_q;
	logic [OUT_WAY_W-1:0]       out_way_q;
	logic                       out_evicted_q;

	// Split the address into set index and tag
	assign addr = ADDR_BITS'(s_axis_tdata);

	generate
		if (LOG_SETS > 0) begin : g_idx
			assign in_set = addr[LOG_SETS-1:0];
		end else begin : g_one_set
			assign in_set = '0;
		end
	endgenerate

	assign in_tag = addr[ADDR_BITS-1:LOG_SETS];

	// Handshake: advance stage 1 when the result register is free or draining
	assign adv_s1        = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Stage 1 control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= in_set;
			tag_s1 <= in_tag;
		end
	end

	sacf_tag_ram #(
		.SET_COUNT (SET_COUNT),
		.WAYS      (WAYS),
		.TAG_W     (TAG_W),
		.SET_W     (SET_W),
		.WAY_W     (WAY_W)
	) u_tag_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_set (in_set),
		.rd_row (rd_row),
		.rd_ptr (rd_ptr),
		.wr_en  (adv_s1 && res.wr_en),
		.wr_set (set_s1),
		.wr_row (new_row),
		.wr_ptr (new_ptr)
	);

	sacf_lookup #(
		.WAYS  (WAYS),
		.TAG_W (TAG_W),
		.WAY_W (WAY_W)
	) u_lookup (
		.tag     (tag_s1),
		.row     (rd_row),
		.vld     (row_vld_s1),
		.ptr     (rd_ptr),
		.res     (res),
		.way     (way),
		.new_row (new_row),
		.new_ptr (new_ptr)
	);

	// Mark the filled way valid on a miss; register the valid bits of the set being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SET_COUNT; s++) begin
				line_vld_q[s] <= '0;
			end
			row_vld_s1 <= '0;
		end else begin
			if (adv_s1 && res.wr_en) begin
				line_vld_q[set_s1][way] <= 1'b1;
			end
			if (accept) begin
				if (adv_s1 && res.wr_en && (set_s1 == in_set)) begin
					row_vld_s1 <= line_vld_q[in_set] | (WAYS'(1) << way);
				end else begin
					row_vld_s1 <= line_vld_q[in_set];
				end
			end
		end
	end

	// Result register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_hit_q     <= res.hit;
			out_way_q     <= OUT_WAY_W'(way);
			out_evicted_q <= res.evicted;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {4'b0000, out_evicted_q, out_way_q, out_hit_q};

`ifndef SYNTHESIS
	// A replacement happens only in a set whose ways are all valid
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res.evicted) |-> (&line_vld_q[set_s1]))
		else $error("eviction in a set with a free way");

	// A hit needs at least one valid way in the set
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res.hit) |-> (|line_vld_q[set_s1]))
		else $error("hit reported in an empty set");

	// The way written on a miss is valid afterwards
	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res.wr_en) |=> line_vld_q[$past(set_s1)][$past(way)])
		else $error("filled way not marked valid");

	// A result never reports both a hit and an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_hit_q && out_evicted_q))
		else $error("hit and eviction reported together");
`endif

endmodule
